// ----- rtl/stkdel_pkg.sv -----
// ----------------------------------------------------------------------------
// stkdel_pkg
// shared types and codes for the stack with delete-by-value
// ----------------------------------------------------------------------------
package stkdel_pkg;

   localparam int WORD_W  = 32;
   localparam int FILL_W  = 5;

   typedef enum logic [1:0] {
      MODE_PUSH   = 2'd0,
      MODE_POP    = 2'd1,
      MODE_PEEK   = 2'd2,
      MODE_DELETE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_EMPTY    = 2'd1,
      ST_NOTFOUND = 2'd2,
      ST_FULL     = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE  = 3'd0,
      S_EXEC  = 3'd1,
      S_READ  = 3'd2,
      S_SCAN  = 3'd3,
      S_SHIFT = 3'd4
   } state_type;

   // read address select
   typedef enum logic [1:0] {
      RD_TOP      = 2'd0,
      RD_PTR_DEC  = 2'd1,
      RD_PTR_INC  = 2'd2,
      RD_PTR_INC2 = 2'd3
   } rd_sel_type;

   typedef enum logic [1:0] {
      PTR_HOLD = 2'd0,
      PTR_TOP  = 2'd1,
      PTR_DEC  = 2'd2,
      PTR_INC  = 2'd3
   } ptr_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD = 2'd0,
      CNT_INC  = 2'd1,
      CNT_DEC  = 2'd2
   } cnt_op_type;

   typedef enum logic [1:0] {
      RV_ZERO = 2'd0,
      RV_ONES = 2'd1,
      RV_READ = 2'd2
   } rv_sel_type;

   // controller -> datapath
   typedef struct packed {
      logic       load_req;
      rd_sel_type rd_sel;
      ptr_op_type ptr_op;
      cnt_op_type cnt_op;
      logic       wr_en;
      logic       wr_shift;
      logic       rsp_en;
      status_type rsp_status;
      rv_sel_type rsp_value_sel;
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      mode_type mode;
      logic     is_full;
      logic     is_empty;
      logic     match;
      logic     ptr_zero;
      logic     ptr_at_top;
      logic     next_at_top;
   } dp_stat_type;

endpackage

// ----- rtl/stkdel_dp.sv -----
// ----------------------------------------------------------------------------
// stkdel_dp
// datapath: entry memory, fill count, scan pointer and result registers
// ----------------------------------------------------------------------------
module stkdel_dp #(
   parameter int DEPTH = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  stkdel_pkg::ctrl_cmd_type     cmd,
   output stkdel_pkg::dp_stat_type      stat,
   input  logic [1:0]                   req_mode,
   input  logic signed [31:0]           req_operand_value,
   output logic                         rsp_valid,
   output logic signed [31:0]           rsp_result_value,
   output logic [1:0]                   rsp_status,
   output logic [4:0]                   rsp_fill_count,
   output logic                         rsp_is_empty
);
   import stkdel_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WORD_W-1:0] mem [DEPTH];

   mode_type          mode_ff;
   logic [WORD_W-1:0] operand_ff;
   logic [CW-1:0]     count_ff;
   logic [CW-1:0]     count_in;
   logic [AW-1:0]     ptr_ff;
   logic [AW-1:0]     ptr_in;
   logic [WORD_W-1:0] rd_data_ff;
   logic [AW-1:0]     rd_addr;
   logic [AW-1:0]     wr_addr;
   logic [WORD_W-1:0] wr_data;
   logic [AW-1:0]     top_idx;
   logic [CW-1:0]     top_cnt;

   logic              rsp_valid_ff;
   logic [WORD_W-1:0] rsp_value_ff;
   logic [WORD_W-1:0] rsp_value_in;
   status_type        rsp_status_ff;
   logic [FILL_W-1:0] rsp_fill_ff;
   logic              rsp_empty_ff;

   assign top_cnt = count_ff - CW'(1);
   assign top_idx = AW'(top_cnt);

   // status toward the controller
   assign stat.mode        = mode_ff;
   assign stat.is_full     = (count_ff == CW'(DEPTH));
   assign stat.is_empty    = (count_ff == '0);
   assign stat.match       = (rd_data_ff == operand_ff);
   assign stat.ptr_zero    = (ptr_ff == '0);
   assign stat.ptr_at_top  = (CW'(ptr_ff) == top_cnt);
   assign stat.next_at_top = ((CW'(ptr_ff) + CW'(1)) == top_cnt);

   always_comb begin
      unique case (cmd.rd_sel)
         RD_TOP:      rd_addr = top_idx;
         RD_PTR_DEC:  rd_addr = ptr_ff - AW'(1);
         RD_PTR_INC:  rd_addr = ptr_ff + AW'(1);
         RD_PTR_INC2: rd_addr = ptr_ff + AW'(2);
         default:     rd_addr = top_idx;
      endcase
   end

   always_comb begin
      unique case (cmd.ptr_op)
         PTR_HOLD: ptr_in = ptr_ff;
         PTR_TOP:  ptr_in = top_idx;
         PTR_DEC:  ptr_in = ptr_ff - AW'(1);
         PTR_INC:  ptr_in = ptr_ff + AW'(1);
         default:  ptr_in = ptr_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.cnt_op)
         CNT_HOLD: count_in = count_ff;
         CNT_INC:  count_in = count_ff + CW'(1);
         CNT_DEC:  count_in = count_ff - CW'(1);
         default:  count_in = count_ff;
      endcase
   end

   assign wr_addr = cmd.wr_shift ? ptr_ff : AW'(count_ff);
   assign wr_data = cmd.wr_shift ? rd_data_ff : operand_ff;

   always_comb begin
      unique case (cmd.rsp_value_sel)
         RV_ZERO: rsp_value_in = '0;
         RV_ONES: rsp_value_in = '1;
         RV_READ: rsp_value_in = rd_data_ff;
         default: rsp_value_in = '0;
      endcase
   end

   // entry memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= cmd.rsp_en;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      if (cmd.load_req) begin
         mode_ff    <= mode_type'(req_mode);
         operand_ff <= req_operand_value;
      end
      if (cmd.rsp_en) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= cmd.rsp_status;
         rsp_fill_ff   <= FILL_W'(count_in);
         rsp_empty_ff  <= (count_in == '0);
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_fill_count   = rsp_fill_ff;
   assign rsp_is_empty     = rsp_empty_ff;

endmodule

// ----- rtl/stkdel_ctrl.sv -----
// ----------------------------------------------------------------------------
// stkdel_ctrl
// controller: sequences push, pop, peek and the delete scan and shift
// ----------------------------------------------------------------------------
module stkdel_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  stkdel_pkg::dp_stat_type  stat,
   output stkdel_pkg::ctrl_cmd_type cmd
);
   import stkdel_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start) state_in = S_EXEC;
         end
         S_EXEC: begin
            unique case (stat.mode)
               MODE_PUSH:   state_in = S_IDLE;
               MODE_POP,
               MODE_PEEK:   state_in = stat.is_empty ? S_IDLE : S_READ;
               MODE_DELETE: state_in = stat.is_empty ? S_IDLE : S_SCAN;
               default:     state_in = S_IDLE;
            endcase
         end
         S_READ: state_in = S_IDLE;
         S_SCAN: begin
            priority if (stat.match) begin
               state_in = stat.ptr_at_top ? S_IDLE : S_SHIFT;
            end else if (stat.ptr_zero) begin
               state_in = S_IDLE;
            end else begin
               state_in = S_SCAN;
            end
         end
         S_SHIFT: begin
            if (stat.next_at_top) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      busy              = (state_ff != S_IDLE);
      cmd.load_req      = 1'b0;
      cmd.rd_sel        = RD_TOP;
      cmd.ptr_op        = PTR_HOLD;
      cmd.cnt_op        = CNT_HOLD;
      cmd.wr_en         = 1'b0;
      cmd.wr_shift      = 1'b0;
      cmd.rsp_en        = 1'b0;
      cmd.rsp_status    = ST_OK;
      cmd.rsp_value_sel = RV_ZERO;
      unique case (state_ff)
         S_IDLE: begin
            cmd.load_req = start;
         end
         S_EXEC: begin
            unique case (stat.mode)
               MODE_PUSH: begin
                  cmd.rsp_en = 1'b1;
                  if (stat.is_full) begin
                     cmd.rsp_status = ST_FULL;
                  end else begin
                     cmd.wr_en  = 1'b1;
                     cmd.cnt_op = CNT_INC;
                  end
               end
               MODE_POP,
               MODE_PEEK: begin
                  if (stat.is_empty) begin
                     cmd.rsp_en        = 1'b1;
                     cmd.rsp_status    = ST_EMPTY;
                     cmd.rsp_value_sel = RV_ONES;
                  end
               end
               MODE_DELETE: begin
                  if (stat.is_empty) begin
                     cmd.rsp_en     = 1'b1;
                     cmd.rsp_status = ST_NOTFOUND;
                  end else begin
                     cmd.ptr_op = PTR_TOP;
                  end
               end
               default: ;
            endcase
         end
         S_READ: begin
            cmd.rsp_en        = 1'b1;
            cmd.rsp_value_sel = RV_READ;
            if (stat.mode == MODE_POP) cmd.cnt_op = CNT_DEC;
         end
         S_SCAN: begin
            priority if (stat.match) begin
               if (stat.ptr_at_top) begin
                  cmd.cnt_op = CNT_DEC;
                  cmd.rsp_en = 1'b1;
               end else begin
                  cmd.rd_sel = RD_PTR_INC;
               end
            end else if (stat.ptr_zero) begin
               cmd.rsp_en     = 1'b1;
               cmd.rsp_status = ST_NOTFOUND;
            end else begin
               cmd.rd_sel = RD_PTR_DEC;
               cmd.ptr_op = PTR_DEC;
            end
         end
         S_SHIFT: begin
            cmd.wr_en    = 1'b1;
            cmd.wr_shift = 1'b1;
            if (stat.next_at_top) begin
               cmd.cnt_op = CNT_DEC;
               cmd.rsp_en = 1'b1;
            end else begin
               cmd.rd_sel = RD_PTR_INC2;
               cmd.ptr_op = PTR_INC;
            end
         end
         default: ;
      endcase
   end

endmodule

// ----- rtl/stack_with_delete_by_value.sv -----
// ----------------------------------------------------------------------------
// stack_with_delete_by_value
// bounded lifo stack of signed words with push, pop, peek and delete-by-value
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  request   req_mode, req_operand_value             start and not busy
//  response  rsp_result_value, rsp_status,           rsp_valid, one cycle
//            rsp_fill_count, rsp_is_empty
//
//  push, or any request that fails at once: busy in the exec state only
//  pop and peek: busy in exec, then read (registered memory read)
//  delete: exec, then scan one entry at a time from the top, then shift the
//  entries above the match down one at a time, through the single read port
//  the response shows in the same cycle that busy drops; the receiver cannot stall
//  reset empties the stack at once; the entry memory itself is not cleared
// ----------------------------------------------------------------------------
module stack_with_delete_by_value #(
   parameter int DEPTH = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_mode,
   input  logic signed [31:0] req_operand_value,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_result_value,
   output logic [1:0]         rsp_status,
   output logic [4:0]         rsp_fill_count,
   output logic               rsp_is_empty
);
   import stkdel_pkg::*;

   // command and status between the controller and the datapath
   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   // sequencer: one state per step of an operation, delete loops in scan/shift
   stkdel_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // entry memory, count, scan pointer and the response registers
   stkdel_dp #(
      .DEPTH (DEPTH)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_mode          (req_mode),
      .req_operand_value (req_operand_value),
      .rsp_valid         (rsp_valid),
      .rsp_result_value  (rsp_result_value),
      .rsp_status        (rsp_status),
      .rsp_fill_count    (rsp_fill_count),
      .rsp_is_empty      (rsp_is_empty)
   );

endmodule

// ----- rtl/stkdel_checker.sv -----
// ----------------------------------------------------------------------------
// stkdel_checker
// port-level checks on the stack, bound to the top level
// ----------------------------------------------------------------------------
module stkdel_checker (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_valid,
   input logic signed [31:0] rsp_result_value,
   input logic [1:0]         rsp_status,
   input logic               rsp_is_empty
);
   import stkdel_pkg::*;

   // an accepted request always sets busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but busy did not rise");

   // one request gives one response, never two in a row
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("back-to-back response strobes");

   // a response follows a busy cycle
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("response without a preceding busy cycle");

   // empty status comes with all ones and an empty stack
   a_empty_rsp: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status == ST_EMPTY) |-> (rsp_is_empty && rsp_result_value == -32'sd1))
      else $error("empty status with wrong value or flag");

endmodule

bind stack_with_delete_by_value stkdel_checker u_stkdel_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .rsp_valid        (rsp_valid),
   .rsp_result_value (rsp_result_value),
   .rsp_status       (rsp_status),
   .rsp_is_empty     (rsp_is_empty)
);

// ----- dv/stkdel_scoreboard_pkg.sv -----
// ----------------------------------------------------------------------------
// stkdel_scoreboard_pkg
// stack predictor and response checker for the stack with delete-by-value
// ----------------------------------------------------------------------------
package stkdel_scoreboard_pkg;

   import stkdel_pkg::*;

   typedef struct packed {
      logic signed [WORD_W-1:0] result_value;
      status_type               status;
      logic [FILL_W-1:0]        fill_count;
      logic                     is_empty;
   } stack_rsp_type;

   class stack_scoreboard #(int DEPTH = 16);

      logic signed [WORD_W-1:0] words [DEPTH];
      int                       held;
      stack_rsp_type            expected_q [$];
      int unsigned              errors;

      function new();
         held   = 0;
         errors = 0;
      endfunction

      // apply one accepted request to the shadow stack, queue its response
      function void note_request(mode_type mode, logic signed [WORD_W-1:0] operand);
         stack_rsp_type rsp;
         int            hit;
         rsp.result_value = '0;
         rsp.status       = ST_OK;
         hit              = -1;
         case (mode)
            MODE_PUSH: begin
               if (held >= DEPTH) begin
                  rsp.status = ST_FULL;
               end else begin
                  words[held] = operand;
                  held++;
               end
            end
            MODE_POP: begin
               if (held == 0) begin
                  rsp.result_value = -1;
                  rsp.status       = ST_EMPTY;
               end else begin
                  held--;
                  rsp.result_value = words[held];
               end
            end
            MODE_PEEK: begin
               if (held == 0) begin
                  rsp.result_value = -1;
                  rsp.status       = ST_EMPTY;
               end else begin
                  rsp.result_value = words[held-1];
               end
            end
            default: begin
               // match nearest the top wins
               for (int i = held - 1; i >= 0; i--) begin
                  if (hit < 0 && words[i] == operand) hit = i;
               end
               if (hit < 0) begin
                  rsp.status = ST_NOTFOUND;
               end else begin
                  for (int j = hit; j < held - 1; j++) words[j] = words[j+1];
                  held--;
               end
            end
         endcase
         rsp.fill_count = held[FILL_W-1:0];
         rsp.is_empty   = (held == 0);
         expected_q.push_back(rsp);
      endfunction

      task report(string msg);
         if (errors < 40) $display("mismatch: %s", msg);
         errors++;
      endtask

      task check_response(logic signed [WORD_W-1:0] value, logic [1:0] status,
                          logic [FILL_W-1:0] fill, logic empty);
         stack_rsp_type want;
         if (expected_q.size() == 0) begin
            report($sformatf("response with none outstanding, value %0d status %0d",
                             value, status));
            return;
         end
         want = expected_q.pop_front();
         if (value !== want.result_value)
            report($sformatf("result_value got %0d want %0d", value, want.result_value));
         if (status !== want.status)
            report($sformatf("status got %0d want %s", status, want.status.name()));
         if (fill !== want.fill_count)
            report($sformatf("fill_count got %0d want %0d", fill, want.fill_count));
         if (empty !== want.is_empty)
            report($sformatf("is_empty got %0b want %0b", empty, want.is_empty));
      endtask

      task report_leftover();
         if (expected_q.size() != 0)
            report($sformatf("%0d responses never arrived", expected_q.size()));
      endtask

      function int pending();
         return expected_q.size();
      endfunction

   endclass

endpackage

// ----- dv/tb_stack_with_delete_by_value.sv -----
// ----------------------------------------------------------------------------
// tb_stack_with_delete_by_value
// drives push, pop, peek and delete requests into the stack, predicts every
// response with a shadow stack and checks each field; directed corner cases
// first, then phased random traffic in bursts with random gaps
// ----------------------------------------------------------------------------
module tb_stack_with_delete_by_value;

   timeunit 1ns;
   timeprecision 1ps;

   import stkdel_pkg::*;
   import stkdel_scoreboard_pkg::*;

   localparam int DEPTH           = 16;
   localparam int RANDOM_REQUESTS = 450;
   // slowest request is a full-depth delete, which scans and shifts the whole stack
   localparam int DRAIN_CYCLES    = 4 * DEPTH + 8;
   localparam int CYCLE_LIMIT     = 200000;

   // traffic phases of the random part
   localparam int PH_FILL  = 0;
   localparam int PH_DRAIN = 1;
   localparam int PH_MIX   = 2;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic [1:0]         req_mode = MODE_PUSH;
   logic signed [31:0] req_operand_value = '0;
   logic               busy;
   logic               rsp_valid;
   logic signed [31:0] rsp_result_value;
   logic [1:0]         rsp_status;
   logic [4:0]         rsp_fill_count;
   logic               rsp_is_empty;

   int unsigned        cycle_count = 0;

   stack_scoreboard #(DEPTH) sb;

   stack_with_delete_by_value #(
      .DEPTH(DEPTH)
   ) dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_mode          (req_mode),
      .req_operand_value (req_operand_value),
      .rsp_valid         (rsp_valid),
      .rsp_result_value  (rsp_result_value),
      .rsp_status        (rsp_status),
      .rsp_fill_count    (rsp_fill_count),
      .rsp_is_empty      (rsp_is_empty)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
   end

   // monitor: responses are checked before the request of the same edge is noted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            sb.check_response(rsp_result_value, rsp_status, rsp_fill_count, rsp_is_empty);
         if (start && !busy)
            sb.note_request(mode_type'(req_mode), req_operand_value);
      end
   end

   // present one request at the falling edge, hold it until the block takes it;
   // returns at the falling edge after acceptance with start still high
   task automatic issue_request(mode_type mode, logic signed [31:0] value);
      start             = 1'b1;
      req_mode          = mode;
      req_operand_value = value;
      forever begin
         @(posedge clock);
         if (!busy) break;
      end
      @(negedge clock);
   endtask

   // sender idle for some cycles, with junk on the request fields
   task automatic idle_gap(int cycles);
      start             = 1'b0;
      req_mode          = 2'($urandom);
      req_operand_value = $urandom;
      repeat (cycles) @(negedge clock);
   endtask

   // operand mix: half from a small pool so deletes hit, plus extremes and noise
   function automatic logic signed [31:0] pick_value();
      int          sel;
      logic [31:0] corner [4];
      sel       = $urandom_range(0, 9);
      corner[0] = 32'h8000_0000;
      corner[1] = 32'h7fff_ffff;
      corner[2] = 32'hffff_ffff;
      corner[3] = 32'h0000_0000;
      if (sel < 5) return int'($urandom_range(0, 7)) - 3;
      if (sel == 5) return corner[$urandom_range(0, 3)];
      return $urandom;
   endfunction

   // delete operand: usually a word that is held somewhere in the stack
   function automatic logic signed [31:0] pick_delete_value();
      if (sb.held > 0 && $urandom_range(0, 9) < 7)
         return sb.words[$urandom_range(0, sb.held - 1)];
      return pick_value();
   endfunction

   function automatic mode_type pick_mode(int phase);
      int roll;
      roll = $urandom_range(0, 9);
      case (phase)
         PH_FILL: begin
            if (roll < 6) return MODE_PUSH;
            if (roll < 7) return MODE_POP;
            if (roll < 8) return MODE_PEEK;
            return MODE_DELETE;
         end
         PH_DRAIN: begin
            if (roll < 1) return MODE_PUSH;
            if (roll < 6) return MODE_POP;
            if (roll < 7) return MODE_PEEK;
            return MODE_DELETE;
         end
         default: return mode_type'(2'($urandom));
      endcase
   endfunction

   task automatic run_directed();
      // empty stack corner cases
      issue_request(MODE_PEEK, 32'sd0);
      issue_request(MODE_POP, 32'sd0);
      issue_request(MODE_DELETE, 32'sd0);
      // extremes of the operand
      issue_request(MODE_PUSH, 32'h8000_0000);
      issue_request(MODE_PUSH, 32'h7fff_ffff);
      issue_request(MODE_PUSH, 32'hffff_ffff);
      issue_request(MODE_PUSH, 32'h0000_0000);
      issue_request(MODE_PEEK, 32'sd0);
      // delete with no match
      issue_request(MODE_DELETE, 32'sd12345);
      // duplicates: delete must take the copy nearest the top
      issue_request(MODE_PUSH, 32'sd5);
      issue_request(MODE_PUSH, 32'sd7);
      issue_request(MODE_PUSH, 32'sd5);
      issue_request(MODE_DELETE, 32'sd5);
      issue_request(MODE_POP, 32'sd0);
      // delete the bottom entry, everything above shifts down
      issue_request(MODE_DELETE, 32'h8000_0000);
      // fill to the top, then a refused push on a full stack
      for (int i = 1; i <= DEPTH - 4; i++)
         issue_request(MODE_PUSH, i * 32'h0101_0101);
      issue_request(MODE_PUSH, 32'sd99);
      // full-depth delete from the bottom
      issue_request(MODE_DELETE, 32'h7fff_ffff);
      issue_request(MODE_PEEK, 32'sd0);
   endtask

   task automatic run_random();
      int       sent;
      int       burst;
      int       phase;
      int       phase_left;
      mode_type mode;
      sent       = 0;
      phase      = PH_FILL;
      phase_left = 0;
      while (sent < RANDOM_REQUESTS) begin
         // long gapless stretches now and then
         burst = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
         for (int k = 0; k < burst; k++) begin
            if (phase_left == 0) begin
               phase      = $urandom_range(PH_FILL, PH_MIX);
               phase_left = $urandom_range(10, 40);
            end
            mode = pick_mode(phase);
            if (mode == MODE_DELETE)
               issue_request(mode, pick_delete_value());
            else
               issue_request(mode, pick_value());
            phase_left--;
            sent++;
         end
         if ($urandom_range(0, 2) != 0)
            idle_gap($urandom_range(1, 8));
      end
   endtask

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      run_directed();
      idle_gap(3);
      run_random();
      idle_gap(1);

      // wait out every outstanding response, then a quiet window for strays
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.report_leftover();

      if (sb.errors == 0) begin
         $display("tb_stack_with_delete_by_value: PASS");
      end else begin
         $display("tb_stack_with_delete_by_value: FAIL");
      end
      $finish;
   end

   // watchdog on the cycle counter
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("tb_stack_with_delete_by_value: FAIL");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/stkdel_pkg.sv
rtl/stkdel_dp.sv
rtl/stkdel_ctrl.sv
rtl/stack_with_delete_by_value.sv
rtl/stkdel_checker.sv
dv/stkdel_scoreboard_pkg.sv
dv/tb_stack_with_delete_by_value.sv
